@@ sv/wdc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and register indexes of the wastegate duty command block.
// No dependencies; every other file refers to it by scoped names.
package wdc_pkg;

    localparam int unsigned QueueDepthDefault = 2;

    // configuration register indexes
    localparam int unsigned CfgIndexW = 3;
    localparam logic [CfgIndexW-1:0] REG_BAT_EN   = 3'd0;
    localparam logic [CfgIndexW-1:0] REG_CUR_EN   = 3'd1;
    localparam logic [CfgIndexW-1:0] REG_RES      = 3'd2;
    localparam logic [CfgIndexW-1:0] REG_NOMINAL  = 3'd3;
    localparam logic [CfgIndexW-1:0] REG_DUTY_MAX = 3'd4;
    localparam logic [CfgIndexW-1:0] REG_DUTY_MIN = 3'd5;
    localparam int unsigned CfgDataW = 16;

    localparam int unsigned ResetNominal = 135;
    localparam int unsigned ResetDutyMax = 1000;

    // battery filter
    localparam int unsigned FiltBias     = 10;
    localparam int unsigned FiltDiv      = 20;
    localparam int unsigned FiltCap      = 200;
    localparam int unsigned FiltSatLevel = FiltCap * FiltDiv + FiltDiv;
    localparam int unsigned Recip5       = 205;
    localparam int unsigned Recip5Shift  = 10;
    localparam int unsigned PrevCap      = 3200;

    // supply and request correction
    localparam int unsigned SupplyScale = 10;
    localparam int unsigned NumMul      = 5;
    localparam int unsigned NumW        = 26;
    localparam int unsigned DivSteps    = NumW;
    localparam int unsigned DivCntW     = $clog2(DivSteps);
    localparam int unsigned CorCap      = 16384;
    localparam int unsigned DutyFull    = 32768;
    localparam int unsigned LimKnee     = DutyFull / 4;

    // calibration map
    localparam int unsigned CalScale       = 1000;
    localparam int unsigned CalRound       = 500;
    localparam int unsigned ScaleW         = 26;
    localparam int unsigned Recip1000      = 68719476;
    localparam int unsigned Recip1000Shift = 36;
    localparam int unsigned RecipProdW     = 53;

    typedef enum logic [1:0] {
        MODE_DIVIDE  = 2'd0,
        MODE_QUARTER = 2'd1,
        MODE_ZERO    = 2'd2
    } t_wdc_mode;

    typedef struct packed {
        logic       bat_en;
        logic       cur_en;
        logic [15:0] resistance;
        logic [7:0]  nominal;
        logic [9:0]  duty_max;
        logic [9:0]  duty_min;
    } t_wdc_cfg;

    typedef struct packed {
        logic [7:0]      filt;
        logic [11:0]     supply;
        t_wdc_mode       mode;
        logic [NumW-1:0] num;
        logic [13:0]     quarter;
    } t_wdc_job;

endpackage

@@ sv/wdc_ifs.sv @@
`timescale 1ns / 1ps
// Handshake channels of the wastegate duty command block: input item, result item, config.
// Depends on wdc_pkg for the config index and data widths.
interface wdc_item_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] battery_sample;
    logic [7:0]         actuator_current;
    logic [15:0]        duty_request;

    modport source (output valid, battery_sample, actuator_current, duty_request, input ready);
    modport sink   (input valid, battery_sample, actuator_current, duty_request, output ready);
endinterface

interface wdc_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  filtered_battery;
    logic [11:0] supply_voltage;
    logic [14:0] corrected_ratio;
    logic [15:0] limited_duty;
    logic [15:0] duty_command;

    modport source (output valid, filtered_battery, supply_voltage, corrected_ratio,
                    limited_duty, duty_command, input ready);
    modport sink   (input valid, filtered_battery, supply_voltage, corrected_ratio,
                    limited_duty, duty_command, output ready);
endinterface

interface wdc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [wdc_pkg::CfgIndexW-1:0] index;
    logic [wdc_pkg::CfgDataW-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/wdc_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts items, filters the battery sample, estimates supply and classifies.
// Depends on wdc_pkg and wdc_item_if; pushes one job per item toward the queue.
module wdc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wdc_item_if.sink          i_item,
    input  wdc_pkg::t_wdc_cfg i_cfg,
    output logic              o_push_valid,
    input  logic              i_push_ready,
    output wdc_pkg::t_wdc_job o_push_job
);

    typedef enum logic [3:0] {
        F_IDLE  = 4'b0001,
        F_CALC1 = 4'b0010,
        F_CALC2 = 4'b0100,
        F_PUSH  = 4'b1000
    } t_front_state;

    t_front_state      r_state, n_state;
    logic [11:0]       r_prev, n_prev;
    logic [17:0]       r_t;
    logic [7:0]        r_current;
    logic [15:0]       r_request;
    logic [23:0]       r_drop;
    logic [23:0]       r_prod;
    logic [7:0]        r_filt, n_filt;
    wdc_pkg::t_wdc_job r_job, n_job;

    logic        w_accept;
    logic [17:0] w_sample_ext;
    logic [9:0]  w_quarter;
    logic [17:0] w_q5;
    logic [7:0]  w_volt;
    logic [23:0] w_drop_eff;
    logic [7:0]  w_head;
    logic [11:0] w_supply;
    logic [26:0] w_num5;

    assign i_item.ready = (r_state == F_IDLE);
    assign w_accept     = i_item.valid && i_item.ready;
    assign o_push_valid = (r_state == F_PUSH);
    assign o_push_job   = r_job;

    assign w_sample_ext = {{2{i_item.battery_sample[15]}}, i_item.battery_sample};

    always_comb begin
        if (i_item.battery_sample[15]) begin
            n_prev = '0;
        end else if (i_item.battery_sample[14:0] > 15'(wdc_pkg::PrevCap)) begin
            n_prev = 12'(wdc_pkg::PrevCap);
        end else begin
            n_prev = i_item.battery_sample[11:0];
        end
    end

    assign w_quarter = r_t[11:2];
    assign w_q5      = 18'(w_quarter) * 18'(wdc_pkg::Recip5);

    always_comb begin
        if (r_t[17] || r_t == '0) begin
            n_filt = '0;
        end else if (r_t[16:0] >= 17'(wdc_pkg::FiltSatLevel)) begin
            n_filt = 8'(wdc_pkg::FiltCap);
        end else begin
            n_filt = w_q5[wdc_pkg::Recip5Shift +: 8];
        end
    end

    assign w_volt     = i_cfg.bat_en ? r_filt : i_cfg.nominal;
    assign w_drop_eff = (i_cfg.bat_en && !i_cfg.cur_en) ? '0 : r_drop;
    assign w_head     = w_volt - w_drop_eff[7:0];
    assign w_supply   = (w_drop_eff > 24'(w_volt)) ? '0
                      : 12'(w_head) * 12'(wdc_pkg::SupplyScale);
    assign w_num5     = 27'(r_prod) * 27'(wdc_pkg::NumMul);

    always_comb begin
        n_job.filt    = r_filt;
        n_job.supply  = w_supply;
        n_job.num     = w_num5[26:1];
        n_job.quarter = r_request[15:2];
        if (!i_cfg.bat_en && !i_cfg.cur_en) begin
            n_job.mode = wdc_pkg::MODE_QUARTER;
        end else if (w_supply == '0) begin
            n_job.mode = wdc_pkg::MODE_ZERO;
        end else begin
            n_job.mode = wdc_pkg::MODE_DIVIDE;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (w_accept) n_state = F_CALC1;
            F_CALC1: n_state = F_CALC2;
            F_CALC2: n_state = F_PUSH;
            F_PUSH:  if (i_push_ready) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_prev  <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_prev <= n_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_t       <= w_sample_ext + 18'(r_prev) + 18'(wdc_pkg::FiltBias);
            r_current <= i_item.actuator_current;
            r_request <= i_item.duty_request;
        end
        if (r_state == F_CALC1) begin
            r_filt <= n_filt;
            r_drop <= 24'(r_current) * 24'(i_cfg.resistance);
            r_prod <= 24'(r_request) * 24'(i_cfg.nominal);
        end
        if (r_state == F_CALC2) begin
            r_job <= n_job;
        end
    end

    a_push_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_PUSH && !i_push_ready) |=> (r_state == F_PUSH && $stable(r_job)))
        else $error("front job changed while stalled");

    a_filt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_CALC2) |-> (r_filt <= 8'(wdc_pkg::FiltCap)))
        else $error("filtered battery out of range");

endmodule

@@ sv/wdc_queue.sv @@
`timescale 1ns / 1ps
// Job queue between front and back end.
// Depends on wdc_pkg for the job type.
module wdc_queue #(
    parameter int unsigned DEPTH = wdc_pkg::QueueDepthDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  wdc_pkg::t_wdc_job i_push_job,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output wdc_pkg::t_wdc_job o_pop_job
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    wdc_pkg::t_wdc_job r_mem [DEPTH];
    logic [PtrW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0]   r_count;

    logic w_push, w_pop;

    assign o_push_ready = (r_count != CntW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    function automatic logic [PtrW-1:0] f_wrap(input logic [PtrW-1:0] ptr);
        f_wrap = (ptr == PtrW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) r_wr_ptr <= f_wrap(r_wr_ptr);
            if (w_pop)  r_rd_ptr <= f_wrap(r_rd_ptr);
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

@@ sv/wdc_back.sv @@
`timescale 1ns / 1ps
// Back end: serial divider, saturation and calibration map, result register.
// Depends on wdc_pkg and wdc_result_if; pops jobs from the queue.
module wdc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wdc_pkg::t_wdc_cfg i_cfg,
    input  logic              i_pop_valid,
    output logic              o_pop_ready,
    input  wdc_pkg::t_wdc_job i_pop_job,
    wdc_result_if.source      o_result
);

    typedef enum logic [6:0] {
        B_IDLE  = 7'b0000001,
        B_DIV   = 7'b0000010,
        B_LIMIT = 7'b0000100,
        B_SCALE = 7'b0001000,
        B_RECIP = 7'b0010000,
        B_FIX   = 7'b0100000,
        B_DONE  = 7'b1000000
    } t_back_state;

    t_back_state                r_state, n_state;
    wdc_pkg::t_wdc_job          r_job;
    logic [11:0]                r_rem;
    logic [wdc_pkg::NumW-1:0]   r_quo;
    logic [wdc_pkg::DivCntW-1:0] r_cnt;
    logic [14:0]                r_cor;
    logic [15:0]                r_lim;
    logic [wdc_pkg::ScaleW-1:0] r_x;
    logic [15:0]                r_q;
    logic                       r_pass;
    logic [15:0]                r_prod, r_base;
    logic                       r_out_valid;
    logic [7:0]                 r_out_filt;
    logic [11:0]                r_out_supply;
    logic [14:0]                r_out_cor;
    logic [15:0]                r_out_lim, r_out_duty;

    logic                           w_pop, w_div_last, w_load_out;
    logic [12:0]                    w_rem_sh, w_rem_diff;
    logic                           w_ge;
    logic [14:0]                    w_cor;
    logic                           w_below;
    logic [9:0]                     w_diff;
    logic [wdc_pkg::RecipProdW-1:0] w_recip;
    logic [wdc_pkg::ScaleW-1:0]     w_fix_rem;
    logic [15:0]                    w_fix_q;
    logic [16:0]                    w_raw;
    logic [15:0]                    w_duty;

    assign o_pop_ready = (r_state == B_IDLE);
    assign w_pop       = i_pop_valid && o_pop_ready;
    assign w_div_last  = (r_cnt == wdc_pkg::DivCntW'(wdc_pkg::DivSteps - 1));
    assign w_load_out  = (r_state == B_DONE) && (!r_out_valid || o_result.ready);

    assign w_rem_sh   = {r_rem, r_quo[wdc_pkg::NumW-1]};
    assign w_rem_diff = w_rem_sh - {1'b0, r_job.supply};
    assign w_ge       = (w_rem_sh >= {1'b0, r_job.supply});

    always_comb begin
        case (r_job.mode)
            wdc_pkg::MODE_DIVIDE:
                w_cor = (r_quo > wdc_pkg::NumW'(wdc_pkg::CorCap)) ? 15'(wdc_pkg::CorCap)
                                                                : r_quo[14:0];
            wdc_pkg::MODE_QUARTER: w_cor = {1'b0, r_job.quarter};
            default:               w_cor = '0;
        endcase
    end

    assign w_below = (i_cfg.duty_max < i_cfg.duty_min);
    assign w_diff  = w_below ? (i_cfg.duty_min - i_cfg.duty_max)
                             : (i_cfg.duty_max - i_cfg.duty_min);

    assign w_recip   = wdc_pkg::RecipProdW'(r_x) * wdc_pkg::RecipProdW'(wdc_pkg::Recip1000);
    assign w_fix_rem = r_x - wdc_pkg::ScaleW'(r_q) * wdc_pkg::ScaleW'(wdc_pkg::CalScale);
    assign w_fix_q   = (w_fix_rem >= wdc_pkg::ScaleW'(wdc_pkg::CalScale)) ? r_q + 1'b1 : r_q;

    assign w_raw  = w_below ? ((r_base >= r_prod) ? 17'(r_base - r_prod) : '0)
                            : 17'(r_base) + 17'(r_prod);
    assign w_duty = (w_raw > 17'(wdc_pkg::DutyFull)) ? 16'(wdc_pkg::DutyFull) : w_raw[15:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (w_pop) begin
                n_state = (i_pop_job.mode == wdc_pkg::MODE_DIVIDE) ? B_DIV : B_LIMIT;
            end
            B_DIV:   if (w_div_last) n_state = B_LIMIT;
            B_LIMIT: n_state = B_SCALE;
            B_SCALE: n_state = B_RECIP;
            B_RECIP: n_state = B_FIX;
            B_FIX:   n_state = r_pass ? B_DONE : B_SCALE;
            B_DONE:  if (w_load_out) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (w_pop) begin
                    r_job <= i_pop_job;
                    r_quo <= i_pop_job.num;
                    r_rem <= '0;
                    r_cnt <= '0;
                end
            end
            B_DIV: begin
                r_rem <= w_ge ? w_rem_diff[11:0] : w_rem_sh[11:0];
                r_quo <= {r_quo[wdc_pkg::NumW-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            B_LIMIT: begin
                r_cor  <= w_cor;
                r_lim  <= (w_cor > 15'(wdc_pkg::LimKnee)) ? 16'(wdc_pkg::DutyFull)
                                                          : 16'({w_cor, 2'b00});
                r_pass <= 1'b0;
            end
            B_SCALE: begin
                r_x <= r_pass ? wdc_pkg::ScaleW'(i_cfg.duty_min) *
                                wdc_pkg::ScaleW'(wdc_pkg::DutyFull) +
                                wdc_pkg::ScaleW'(wdc_pkg::CalRound)
                              : wdc_pkg::ScaleW'(w_diff) * wdc_pkg::ScaleW'(r_lim);
            end
            B_RECIP: begin
                r_q <= w_recip[wdc_pkg::Recip1000Shift +: 16];
            end
            B_FIX: begin
                if (r_pass) begin
                    r_base <= w_fix_q;
                end else begin
                    r_prod <= w_fix_q;
                    r_pass <= 1'b1;
                end
            end
            B_DONE: begin
                if (w_load_out) begin
                    r_out_filt   <= r_job.filt;
                    r_out_supply <= r_job.supply;
                    r_out_cor    <= r_cor;
                    r_out_lim    <= r_lim;
                    r_out_duty   <= w_duty;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.filtered_battery = r_out_filt;
    assign o_result.supply_voltage   = r_out_supply;
    assign o_result.corrected_ratio  = r_out_cor;
    assign o_result.limited_duty     = r_out_lim;
    assign o_result.duty_command     = r_out_duty;

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_lim <= 16'(wdc_pkg::DutyFull) &&
                         r_out_duty <= 16'(wdc_pkg::DutyFull) &&
                         r_out_cor <= 15'(wdc_pkg::CorCap)))
        else $error("result field out of range");

    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV && w_div_last) |=> (r_state == B_LIMIT))
        else $error("divider did not finish after its last step");

    a_recip_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FIX) |->
            (w_fix_rem < wdc_pkg::ScaleW'(2 * wdc_pkg::CalScale)))
        else $error("reciprocal quotient off by more than one");

endmodule

@@ sv/wastegate_duty_command_top.sv @@
`timescale 1ns / 1ps
// Wastegate duty command top level: config registers, front end, job queue, back end.
// Depends on wdc_pkg, wdc_ifs, wdc_front, wdc_queue and wdc_back.
//
// One result item per input item, in order. The front end accepts an item, computes in two
// states (CALC1, CALC2) and hands the job to the queue before it accepts the next one; the
// back end runs an item whose request is rescaled by the supply voltage through the
// one-bit-per-cycle 26-step divider and skips the divider otherwise (both corrections off,
// or a supply estimate of zero), so rescaled requests hold the back end longer. The front
// end can take new items while the back end still works; QUEUE_DEPTH jobs may wait
// between the two ends, and a finished result sits in an output register while the next
// item is worked on. Configuration writes are always accepted and take effect at once;
// write them only while no item is in flight.
module wastegate_duty_command_top #(
    parameter int unsigned QUEUE_DEPTH = wdc_pkg::QueueDepthDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wdc_cfg_if.sink      i_cfg,
    wdc_item_if.sink     i_item,
    wdc_result_if.source o_result
);

    wdc_pkg::t_wdc_cfg r_cfg;
    logic              w_cfg_write;
    logic              w_push_valid, w_push_ready, w_pop_valid, w_pop_ready;
    wdc_pkg::t_wdc_job w_push_job, w_pop_job;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_write = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bat_en     <= 1'b0;
            r_cfg.cur_en     <= 1'b0;
            r_cfg.resistance <= '0;
            r_cfg.nominal    <= 8'(wdc_pkg::ResetNominal);
            r_cfg.duty_max   <= 10'(wdc_pkg::ResetDutyMax);
            r_cfg.duty_min   <= '0;
        end else if (w_cfg_write) begin
            case (i_cfg.index)
                wdc_pkg::REG_BAT_EN:   r_cfg.bat_en     <= i_cfg.data[0];
                wdc_pkg::REG_CUR_EN:   r_cfg.cur_en     <= i_cfg.data[0];
                wdc_pkg::REG_RES:      r_cfg.resistance <= i_cfg.data;
                wdc_pkg::REG_NOMINAL:  r_cfg.nominal    <= i_cfg.data[7:0];
                wdc_pkg::REG_DUTY_MAX: r_cfg.duty_max   <= i_cfg.data[9:0];
                wdc_pkg::REG_DUTY_MIN: r_cfg.duty_min   <= i_cfg.data[9:0];
                default: begin
                end
            endcase
        end
    end

    wdc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_cfg        (r_cfg),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_job   (w_push_job)
    );

    wdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_job   (w_push_job),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_job    (w_pop_job)
    );

    wdc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_job   (w_pop_job),
        .o_result    (o_result)
    );

endmodule

@@ tb/sv/wastegate_duty_command_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for wastegate_duty_command_top: directed rows, then randomized phases.
// Depends on wdc_pkg, the wdc_ifs channels and the top level; predicts every result in-bench.
module wastegate_duty_command_top_tb;

    typedef struct packed {
        logic [7:0]  filtered_battery;
        logic [11:0] supply_voltage;
        logic [14:0] corrected_ratio;
        logic [15:0] limited_duty;
        logic [15:0] duty_command;
    } t_duty_result;

    typedef struct packed {
        bit                            is_write;
        logic [wdc_pkg::CfgIndexW-1:0] index;
        logic [15:0]                   data;
        logic signed [15:0]            battery;
        logic [7:0]                    current;
        logic [15:0]                   request;
        bit                            known;
        t_duty_result                  duty;
    } t_plan_row;

    logic i_clk;
    logic i_rst_n;

    wdc_cfg_if    cfg_if();
    wdc_item_if   item_if();
    wdc_result_if res_if();

    wastegate_duty_command_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_if),
        .i_item   (item_if),
        .o_result (res_if)
    );

    wdc_pkg::t_wdc_cfg duty_cfg;
    logic [11:0]       battery_hold;
    t_duty_result      pending_duty_q[$];
    t_duty_result      head_duty;
    t_plan_row         plan[$];

    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned items_sent     = 0;
    int unsigned settings_run   = 0;
    int unsigned burst_left     = 0;
    int unsigned ready_run      = 0;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    initial begin
        #5_000_000;
        $display("wastegate_duty_command_top_tb failed");
        $finish;
    end

    function automatic t_duty_result predict_duty(logic signed [15:0] sample,
                                                  logic [7:0] current, logic [15:0] request);
        t_duty_result r;
        longint avg, filt, drop, supply, ratio, lim, cal_max, cal_min, diff, prod, base, duty;
        avg = longint'(sample) + longint'(battery_hold) + 10;
        if (avg <= 0) begin
            filt = 0;
        end else begin
            filt = avg / 20;
            if (filt > 200) filt = 200;
        end
        if (sample < 0) battery_hold = 12'd0;
        else if (sample > 3200) battery_hold = 12'd3200;
        else battery_hold = 12'(sample);

        drop = longint'(current) * longint'(duty_cfg.resistance);
        if (duty_cfg.bat_en) begin
            supply = duty_cfg.cur_en ? (filt - drop) * 10 : filt * 10;
        end else begin
            supply = (longint'(duty_cfg.nominal) - drop) * 10;
        end
        if (supply < 0) supply = 0;

        if (duty_cfg.bat_en || duty_cfg.cur_en) begin
            if (supply != 0)
                ratio = ((longint'(request) * longint'(duty_cfg.nominal) * 5) / 2) / supply;
            else
                ratio = 0;
        end else begin
            ratio = longint'(request) / 4;
        end
        if (ratio > 16384) ratio = 16384;
        lim = ratio * 4;
        if (lim > 32768) lim = 32768;

        cal_max = longint'(duty_cfg.duty_max);
        cal_min = longint'(duty_cfg.duty_min);
        diff = (cal_max < cal_min) ? cal_min - cal_max : cal_max - cal_min;
        prod = (diff * lim) / 1000;
        base = (cal_min * 32768 + 500) / 1000;
        duty = (cal_max < cal_min) ? base - prod : base + prod;
        if (duty < 0) duty = 0;
        if (duty > 32768) duty = 32768;

        r.filtered_battery = 8'(filt);
        r.supply_voltage   = 12'(supply);
        r.corrected_ratio  = 15'(ratio);
        r.limited_duty     = 16'(lim);
        r.duty_command     = 16'(duty);
        return r;
    endfunction

    function automatic t_plan_row reg_row(logic [wdc_pkg::CfgIndexW-1:0] index,
                                         logic [15:0] data);
        t_plan_row row;
        row = '0;
        row.is_write = 1'b1;
        row.index    = index;
        row.data     = data;
        return row;
    endfunction

    function automatic t_plan_row item_row(logic signed [15:0] battery, logic [7:0] current,
                                           logic [15:0] request);
        t_plan_row row;
        row = '0;
        row.battery = battery;
        row.current = current;
        row.request = request;
        return row;
    endfunction

    function automatic t_plan_row known_row(logic signed [15:0] battery, logic [7:0] current,
                                            logic [15:0] request, int filt, int supply,
                                            int ratio, int lim, int duty);
        t_plan_row row;
        row = item_row(battery, current, request);
        row.known = 1'b1;
        row.duty  = '{8'(filt), 12'(supply), 15'(ratio), 16'(lim), 16'(duty)};
        return row;
    endfunction

    function automatic void check_field(string field, int want, int got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch on result %0d, %s: expected %0d, got %0d",
                         results_seen, field, want, got);
        end
    endfunction

    function automatic logic [9:0] pick_calibration();
        case ($urandom_range(0, 5))
            0: return 10'd0;
            1: return 10'd1000;
            2: return 10'd1023;
            3: return 10'($urandom_range(1001, 1023));
            default: return 10'($urandom_range(0, 1000));
        endcase
    endfunction

    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (ready_run == 0) begin
                case ($urandom_range(0, 7))
                    0: begin
                        res_if.ready <= 1'b1;
                        ready_run = $urandom_range(100, 300);
                    end
                    1, 2, 3: begin
                        res_if.ready <= 1'b0;
                        ready_run = $urandom_range(1, 8);
                    end
                    default: begin
                        res_if.ready <= 1'b1;
                        ready_run = $urandom_range(1, 20);
                    end
                endcase
            end else begin
                ready_run = ready_run - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_duty_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result item with no item outstanding: duty %0d",
                             res_if.duty_command);
            end else begin
                head_duty = pending_duty_q.pop_front();
                check_field("filtered_battery", int'(head_duty.filtered_battery),
                            int'(res_if.filtered_battery));
                check_field("supply_voltage", int'(head_duty.supply_voltage),
                            int'(res_if.supply_voltage));
                check_field("corrected_ratio", int'(head_duty.corrected_ratio),
                            int'(res_if.corrected_ratio));
                check_field("limited_duty", int'(head_duty.limited_duty),
                            int'(res_if.limited_duty));
                check_field("duty_command", int'(head_duty.duty_command),
                            int'(res_if.duty_command));
                results_seen++;
            end
        end
    end

    task automatic send_item(input logic signed [15:0] battery, input logic [7:0] current,
                             input logic [15:0] request, input bit known,
                             input t_duty_result known_duty);
        int unsigned gap;
        t_duty_result model_duty;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                item_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        item_if.valid            <= 1'b1;
        item_if.battery_sample   <= battery;
        item_if.actuator_current <= current;
        item_if.duty_request     <= request;
        do @(posedge i_clk); while (!item_if.ready);
        model_duty = predict_duty(battery, current, request);
        pending_duty_q.push_back(known ? known_duty : model_duty);
        items_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [wdc_pkg::CfgIndexW-1:0] index,
                             input logic [15:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (index)
            wdc_pkg::REG_BAT_EN:   duty_cfg.bat_en     = data[0];
            wdc_pkg::REG_CUR_EN:   duty_cfg.cur_en     = data[0];
            wdc_pkg::REG_RES:      duty_cfg.resistance = data;
            wdc_pkg::REG_NOMINAL:  duty_cfg.nominal    = data[7:0];
            wdc_pkg::REG_DUTY_MAX: duty_cfg.duty_max   = data[9:0];
            wdc_pkg::REG_DUTY_MIN: duty_cfg.duty_min   = data[9:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // hold off until every result is back, leaving the block idle
    task automatic settle();
        item_if.valid <= 1'b0;
        while (pending_duty_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        settings_run++;
    endtask

    initial begin
        bit                 writing;
        int unsigned        count;
        logic signed [15:0] battery;
        logic [7:0]         current;
        logic [15:0]        request;
        logic [15:0]        resistance;

        i_rst_n                  = 1'b0;
        cfg_if.valid             = 1'b0;
        cfg_if.index             = '0;
        cfg_if.data              = '0;
        item_if.valid            = 1'b0;
        item_if.battery_sample   = '0;
        item_if.actuator_current = '0;
        item_if.duty_request     = '0;

        duty_cfg     = '{1'b0, 1'b0, 16'd0, 8'(wdc_pkg::ResetNominal),
                         10'(wdc_pkg::ResetDutyMax), 10'd0};
        battery_hold = 12'd0;

        plan.push_back(known_row(16'sd0, 8'd0, 16'd0, 0, 1350, 0, 0, 0));
        plan.push_back(known_row(16'sd32767, 8'd255, 16'd65535, 200, 1350, 16383, 32768, 32768));
        plan.push_back(known_row(-16'sd32768, 8'd0, 16'd65535, 0, 1350, 16383, 32768, 32768));
        plan.push_back(known_row(-16'sd1, 8'd0, 16'd4, 0, 1350, 1, 4, 4));
        plan.push_back(item_row(16'sd3200, 8'd0, 16'd65532));
        plan.push_back(reg_row(wdc_pkg::REG_BAT_EN, 16'd1));
        plan.push_back(item_row(16'sd3200, 8'd0, 16'd1000));
        plan.push_back(known_row(-16'sd32768, 8'd0, 16'd65535, 0, 0, 0, 0, 0));
        plan.push_back(item_row(16'sd20, 8'd0, 16'd65535));
        plan.push_back(reg_row(wdc_pkg::REG_CUR_EN, 16'd1));
        plan.push_back(reg_row(wdc_pkg::REG_RES, 16'd65535));
        plan.push_back(known_row(16'sd1000, 8'd255, 16'd65535, 51, 0, 0, 0, 0));
        plan.push_back(reg_row(wdc_pkg::REG_RES, 16'd1));
        plan.push_back(item_row(16'sd3200, 8'd5, 16'd40000));
        plan.push_back(reg_row(wdc_pkg::REG_BAT_EN, 16'd0));
        plan.push_back(item_row(16'sd100, 8'd10, 16'd30000));
        plan.push_back(reg_row(wdc_pkg::REG_NOMINAL, 16'd255));
        plan.push_back(item_row(16'sd2500, 8'd0, 16'd65535));
        plan.push_back(reg_row(wdc_pkg::REG_NOMINAL, 16'd0));
        plan.push_back(known_row(16'sd2500, 8'd0, 16'd65535, 200, 0, 0, 0, 0));
        plan.push_back(reg_row(wdc_pkg::REG_NOMINAL, 16'd135));
        plan.push_back(reg_row(wdc_pkg::REG_CUR_EN, 16'd0));
        plan.push_back(reg_row(wdc_pkg::REG_DUTY_MIN, 16'd1023));
        plan.push_back(reg_row(wdc_pkg::REG_DUTY_MAX, 16'd0));
        plan.push_back(item_row(16'sd0, 8'd0, 16'd0));
        plan.push_back(item_row(16'sd0, 8'd0, 16'd65535));
        plan.push_back(item_row(16'sd0, 8'd0, 16'd32768));
        plan.push_back(reg_row(wdc_pkg::REG_DUTY_MIN, 16'd0));
        plan.push_back(reg_row(wdc_pkg::REG_DUTY_MAX, 16'd1023));
        plan.push_back(item_row(16'sd0, 8'd0, 16'd65535));
        plan.push_back(item_row(16'sd0, 8'd0, 16'd32000));
        plan.push_back(reg_row(wdc_pkg::REG_DUTY_MIN, 16'd1000));
        plan.push_back(reg_row(wdc_pkg::REG_DUTY_MAX, 16'd1000));
        plan.push_back(item_row(16'sd0, 8'd0, 16'd12345));
        plan.push_back(reg_row(wdc_pkg::REG_DUTY_MIN, 16'd250));
        plan.push_back(reg_row(wdc_pkg::REG_DUTY_MAX, 16'd750));
        plan.push_back(item_row(16'sd1234, 8'd77, 16'd20000));

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        writing = 1'b0;
        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                if (!writing) settle();
                writing = 1'b1;
                write_reg(plan[i].index, plan[i].data);
            end else begin
                if (writing) cfg_if.valid <= 1'b0;
                writing = 1'b0;
                send_item(plan[i].battery, plan[i].current, plan[i].request,
                          plan[i].known, plan[i].duty);
            end
        end

        for (int phase = 0; phase < 14; phase++) begin
            settle();
            case ($urandom_range(0, 7))
                0: resistance = 16'd0;
                1: resistance = 16'd65535;
                2: resistance = 16'($urandom_range(0, 65535));
                default: resistance = 16'($urandom_range(1, 4));
            endcase
            write_reg(wdc_pkg::REG_BAT_EN, 16'($urandom_range(0, 1)));
            write_reg(wdc_pkg::REG_CUR_EN, 16'($urandom_range(0, 1)));
            write_reg(wdc_pkg::REG_RES, resistance);
            write_reg(wdc_pkg::REG_NOMINAL, ($urandom_range(0, 3) == 0) ?
                      16'($urandom_range(0, 1) * 255) : 16'($urandom_range(0, 255)));
            write_reg(wdc_pkg::REG_DUTY_MAX, 16'(pick_calibration()));
            write_reg(wdc_pkg::REG_DUTY_MIN, 16'(pick_calibration()));
            cfg_if.valid <= 1'b0;

            count = $urandom_range(80, 120);
            repeat (count) begin
                case ($urandom_range(0, 9))
                    0, 1: battery = 16'($urandom_range(0, 65535));
                    2: begin
                        case ($urandom_range(0, 5))
                            0: battery = -16'sd32768;
                            1: battery = 16'sd32767;
                            2: battery = 16'sd0;
                            3: battery = 16'sd3200;
                            4: battery = 16'sd3201;
                            default: battery = -16'sd1;
                        endcase
                    end
                    default: battery = 16'($urandom_range(0, 4000));
                endcase
                current = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, 3));
                case ($urandom_range(0, 19))
                    0: request = 16'd0;
                    1: request = 16'd65535;
                    default: request = 16'($urandom_range(0, 65535));
                endcase
                send_item(battery, current, request, 1'b0, '0);
            end
        end

        settle();
        repeat (60) @(posedge i_clk);

        if (pending_duty_q.size() != 0)
            $display("%0d result items never arrived", pending_duty_q.size());
        $display("Sent %0d items under %0d register settings, checked %0d results, %0d mismatches",
                 items_sent, settings_run, results_seen, mismatch_count);
        if (mismatch_count == 0 && pending_duty_q.size() == 0) begin
            $display("wastegate_duty_command_top_tb passed");
        end else begin
            $display("wastegate_duty_command_top_tb failed");
        end
        $finish;
    end
endmodule
